[hdl/cmm_pkg.sv]
// Shared types, address map constants and sizes for the console memory map.
package cmm_pkg;

	localparam int ROM_BANK_BYTES  = 16384;
	localparam int ROM_OFS_W       = $clog2(ROM_BANK_BYTES);
	localparam int ROM_DEPTH       = 2 * ROM_BANK_BYTES;
	localparam int ROM_ADDR_W      = $clog2(ROM_DEPTH);
	localparam int FLAT_DEPTH      = 65536;
	localparam int FLAT_ADDR_W     = $clog2(FLAT_DEPTH);
	localparam int VRAM_BANK_DEPTH = 4096;
	localparam int VRAM_IDX_W      = $clog2(VRAM_BANK_DEPTH);
	localparam int HRAM_DEPTH      = 128;
	localparam int HRAM_ADDR_W     = $clog2(HRAM_DEPTH);

	localparam logic [15:0] ADDR_JOYP      = 16'hFF00;
	localparam logic [15:0] ADDR_DIV       = 16'hFF04;
	localparam logic [15:0] ADDR_TIMA      = 16'hFF05;
	localparam logic [15:0] ADDR_TMA       = 16'hFF06;
	localparam logic [15:0] ADDR_TAC       = 16'hFF07;
	localparam logic [15:0] ADDR_LCDC      = 16'hFF40;
	localparam logic [15:0] ADDR_SCY       = 16'hFF42;
	localparam logic [15:0] ADDR_SCX       = 16'hFF43;
	localparam logic [15:0] ADDR_LY        = 16'hFF44;
	localparam logic [15:0] ADDR_BOOT_OFF  = 16'hFF50;
	localparam logic [15:0] ADDR_HRAM_LO   = 16'hFF80;
	localparam logic [15:0] ADDR_HRAM_HI   = 16'hFFFE;
	localparam logic [15:0] ADDR_UNUSED_LO = 16'hFEA0;
	localparam logic [15:0] ADDR_UNUSED_HI = 16'hFEFF;
	localparam logic [15:0] ADDR_ECHO_LO   = 16'hE000;
	localparam logic [15:0] ADDR_ECHO_END  = 16'hFE00;
	localparam logic [15:0] ECHO_OFFSET    = 16'h2000;
	localparam logic [15:0] ADDR_VRAM_LO   = 16'h8000;
	localparam logic [15:0] ADDR_VRAM_HI   = 16'h9FFF;
	localparam logic [15:0] ADDR_TILE_HI   = 16'h97FF;
	localparam logic [15:0] ADDR_BOOT_END  = 16'h0100;
	localparam logic [15:0] ADDR_ROM_END   = 16'h8000;

	localparam logic [1:0] JOYP_COL_ONE = 2'd1;
	localparam logic [1:0] JOYP_COL_TWO = 2'd2;

	typedef enum logic [1:0] {
		OP_READ     = 2'd0,
		OP_WRITE    = 2'd1,
		OP_LOAD_ROM = 2'd2,
		OP_LOAD_RAM = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		SRC_ZERO,
		SRC_REG,
		SRC_VRAM,
		SRC_ROM,
		SRC_HIGH,
		SRC_FLAT
	} src_t;

	typedef struct packed {
		logic [1:0]  op;
		logic [15:0] address;
		logic [7:0]  data;
		logic        rom_bank;
		logic [7:0]  keys_group_one;
		logic [7:0]  keys_group_two;
		logic [7:0]  current_scanline;
		logic [7:0]  divider_value;
	} cmm_in_t;

	typedef struct packed {
		logic [7:0]  read_data;
		logic        access_fault;
		logic        tile_row_valid;
		logic [8:0]  tile_number;
		logic [2:0]  tile_row_number;
		logic [15:0] tile_pixels;
		logic        background_touched;
	} cmm_out_t;

	typedef struct packed {
		logic       hit;
		logic [7:0] data;
	} cmm_io_rd_t;

	typedef struct packed {
		logic                   flat_we;
		logic [FLAT_ADDR_W-1:0] flat_addr;
		logic                   rom_we;
		logic [ROM_ADDR_W-1:0]  rom_addr;
		logic                   vram_even_we;
		logic                   vram_odd_we;
		logic [VRAM_IDX_W-1:0]  vram_idx;
		logic                   high_we;
		logic [HRAM_ADDR_W-1:0] high_addr;
	} cmm_mem_t;

	typedef struct packed {
		src_t       src;
		logic       fault;
		logic [7:0] reg_byte;
		logic       odd;
		logic [7:0] data;
		logic       tile_valid;
		logic [8:0] tile_number;
		logic [2:0] tile_row;
		logic       bg_touched;
	} cmm_s1_t;

endpackage

[hdl/console_memory_map_with_tile_decode.sv]
// Top level of the console memory map with tile row decode.
// Usage:
//   req channel (req_valid, req_stall, req) carries one bus access per item:
//   read, write, ROM byte load or raw RAM byte load. rsp channel (rsp_valid,
//   rsp_stall, rsp) returns exactly one result item per access, in order.
//   cfg channel (cfg_valid, cfg_ready, cfg_data) writes single_bank_q and is
//   always ready; the user must write it only while the bus is idle, unchecked.
// Timing:
//   One item per cycle sustained while rsp_stall stays low. The edge that
//   accepts an item issues the synchronous memory access and registers the
//   decode into the first stage; the move out of that stage registers the
//   result, as set by the registered read port of each memory.
// Reset:
//   After arst_n releases, a clearing pass zeroes flat RAM, video RAM and high
//   RAM, one address per cycle, over every flat RAM address; req_stall stays
//   high for the whole pass. ROM contents are undefined until loaded.
// Stall:
//   While rsp_stall holds a result, one more item is accepted into the first
//   stage; after that req_stall rises until the result is taken.
module console_memory_map_with_tile_decode (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  cmm_pkg::cmm_in_t  req,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output cmm_pkg::cmm_out_t rsp,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic              cfg_data
);

	logic                                clr_busy_q;
	logic [cmm_pkg::FLAT_ADDR_W-1:0]     clr_cnt_q;
	logic                                single_bank_q;
	logic                                accept;
	logic                                s1_valid_q;
	logic                                s1_move;
	cmm_pkg::cmm_s1_t                    s1_s1;
	cmm_pkg::cmm_s1_t                    dec_s1;
	cmm_pkg::cmm_mem_t                   mem;
	cmm_pkg::cmm_io_rd_t                 io_rd;
	logic                                boot_off;
	cmm_pkg::cmm_out_t                   res;
	cmm_pkg::cmm_out_t                   rsp_q;
	logic                                rsp_valid_q;
	logic [7:0]                          wdata;
	logic [7:0]                          flat_rd;
	logic [7:0]                          rom_rd;
	logic [7:0]                          vram_even_rd;
	logic [7:0]                          vram_odd_rd;
	logic [7:0]                          high_rd;

	assign cfg_ready = 1'b1;
	assign accept    = req_valid && !req_stall;
	assign s1_move   = s1_valid_q && (!rsp_valid_q || !rsp_stall);
	assign req_stall = clr_busy_q || (s1_valid_q && !s1_move);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign wdata     = clr_busy_q ? 8'd0 : req.data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			single_bank_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			single_bank_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_cnt_q  <= '0;
		end else if (clr_busy_q) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
			if (&clr_cnt_q) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			s1_valid_q <= accept || (s1_valid_q && !s1_move);
			if (s1_move) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			s1_s1 <= dec_s1;
		end
		if (s1_move) begin
			rsp_q <= res;
		end
	end

	cmm_io_regs u_io_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.item     (req),
		.boot_off (boot_off),
		.io_rd    (io_rd)
	);

	cmm_decode u_decode (
		.item        (req),
		.boot_off    (boot_off),
		.single_bank (single_bank_q),
		.io_rd       (io_rd),
		.mem         (mem),
		.s1          (dec_s1)
	);

	cmm_ram #(
		.WIDTH (8),
		.DEPTH (cmm_pkg::FLAT_DEPTH)
	) u_flat_ram (
		.clk   (clk),
		.we    (clr_busy_q || (accept && mem.flat_we)),
		.waddr (clr_busy_q ? clr_cnt_q : mem.flat_addr),
		.wdata (wdata),
		.re    (accept),
		.raddr (mem.flat_addr),
		.rdata (flat_rd)
	);

	cmm_ram #(
		.WIDTH (8),
		.DEPTH (cmm_pkg::ROM_DEPTH)
	) u_rom (
		.clk   (clk),
		.we    (accept && mem.rom_we),
		.waddr (mem.rom_addr),
		.wdata (req.data),
		.re    (accept),
		.raddr (mem.rom_addr),
		.rdata (rom_rd)
	);

	cmm_ram #(
		.WIDTH (8),
		.DEPTH (cmm_pkg::VRAM_BANK_DEPTH)
	) u_vram_even (
		.clk   (clk),
		.we    (clr_busy_q || (accept && mem.vram_even_we)),
		.waddr (clr_busy_q ? clr_cnt_q[cmm_pkg::VRAM_IDX_W-1:0] : mem.vram_idx),
		.wdata (wdata),
		.re    (accept),
		.raddr (mem.vram_idx),
		.rdata (vram_even_rd)
	);

	cmm_ram #(
		.WIDTH (8),
		.DEPTH (cmm_pkg::VRAM_BANK_DEPTH)
	) u_vram_odd (
		.clk   (clk),
		.we    (clr_busy_q || (accept && mem.vram_odd_we)),
		.waddr (clr_busy_q ? clr_cnt_q[cmm_pkg::VRAM_IDX_W-1:0] : mem.vram_idx),
		.wdata (wdata),
		.re    (accept),
		.raddr (mem.vram_idx),
		.rdata (vram_odd_rd)
	);

	cmm_ram #(
		.WIDTH (8),
		.DEPTH (cmm_pkg::HRAM_DEPTH)
	) u_high_ram (
		.clk   (clk),
		.we    (clr_busy_q || (accept && mem.high_we)),
		.waddr (clr_busy_q ? clr_cnt_q[cmm_pkg::HRAM_ADDR_W-1:0] : mem.high_addr),
		.wdata (wdata),
		.re    (accept),
		.raddr (mem.high_addr),
		.rdata (high_rd)
	);

	cmm_result u_result (
		.s1           (s1_s1),
		.flat_rd      (flat_rd),
		.rom_rd       (rom_rd),
		.vram_even_rd (vram_even_rd),
		.vram_odd_rd  (vram_odd_rd),
		.high_rd      (high_rd),
		.res          (res)
	);

endmodule

[hdl/cmm_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module cmm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[hdl/cmm_io_regs.sv]
// I/O register file: joypad select, scroll, LCD control, timer and boot overlay.
module cmm_io_regs (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  cmm_pkg::cmm_in_t    item,
	output logic                boot_off,
	output cmm_pkg::cmm_io_rd_t io_rd
);

	logic       boot_off_q;
	logic [1:0] joyp_col_q;
	logic [7:0] scy_q;
	logic [7:0] scx_q;
	logic [7:0] lcdc_q;
	logic [7:0] tima_q;
	logic [7:0] tma_q;
	logic [2:0] tac_q;
	logic       wr;

	assign wr       = accept && (cmm_pkg::op_t'(item.op) == cmm_pkg::OP_WRITE);
	assign boot_off = boot_off_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			boot_off_q <= 1'b0;
			joyp_col_q <= 2'd0;
			scy_q      <= 8'd0;
			scx_q      <= 8'd0;
			lcdc_q     <= 8'd0;
			tima_q     <= 8'd0;
			tma_q      <= 8'd0;
			tac_q      <= 3'd0;
		end else if (wr) begin
			case (item.address)
				cmm_pkg::ADDR_JOYP:     joyp_col_q <= item.data[5:4];
				cmm_pkg::ADDR_BOOT_OFF: boot_off_q <= 1'b1;
				cmm_pkg::ADDR_SCY:      scy_q      <= item.data;
				cmm_pkg::ADDR_SCX:      scx_q      <= item.data;
				cmm_pkg::ADDR_LCDC:     lcdc_q     <= item.data;
				cmm_pkg::ADDR_TIMA:     tima_q     <= item.data;
				cmm_pkg::ADDR_TMA:      tma_q      <= item.data;
				cmm_pkg::ADDR_TAC:      tac_q      <= item.data[2:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		io_rd.hit  = 1'b1;
		io_rd.data = 8'd0;
		case (item.address)
			cmm_pkg::ADDR_JOYP: begin
				if (joyp_col_q == cmm_pkg::JOYP_COL_ONE) begin
					io_rd.data = item.keys_group_one;
				end else if (joyp_col_q == cmm_pkg::JOYP_COL_TWO) begin
					io_rd.data = item.keys_group_two;
				end
			end
			cmm_pkg::ADDR_SCY:  io_rd.data = scy_q;
			cmm_pkg::ADDR_SCX:  io_rd.data = scx_q;
			cmm_pkg::ADDR_LCDC: io_rd.data = lcdc_q;
			cmm_pkg::ADDR_LY:   io_rd.data = item.current_scanline;
			cmm_pkg::ADDR_DIV:  io_rd.data = item.divider_value;
			cmm_pkg::ADDR_TIMA: io_rd.data = tima_q;
			cmm_pkg::ADDR_TMA:  io_rd.data = tma_q;
			cmm_pkg::ADDR_TAC:  io_rd.data = {5'd0, tac_q};
			default:            io_rd.hit  = 1'b0;
		endcase
	end

endmodule

[hdl/cmm_decode.sv]
// Address decode of one access into memory controls and first-stage fields.
module cmm_decode (
	input  cmm_pkg::cmm_in_t    item,
	input  logic                boot_off,
	input  logic                single_bank,
	input  cmm_pkg::cmm_io_rd_t io_rd,
	output cmm_pkg::cmm_mem_t   mem,
	output cmm_pkg::cmm_s1_t    s1
);

	cmm_pkg::op_t op;
	logic [15:0]  a;
	logic [15:0]  a2;
	logic         unused;
	logic         vram;
	logic         high;
	logic         wr;

	always_comb begin
		op     = cmm_pkg::op_t'(item.op);
		a      = item.address;
		a2     = (a >= cmm_pkg::ADDR_ECHO_LO && a < cmm_pkg::ADDR_ECHO_END) ?
		         a - cmm_pkg::ECHO_OFFSET : a;
		unused = a >= cmm_pkg::ADDR_UNUSED_LO && a <= cmm_pkg::ADDR_UNUSED_HI;
		vram   = a >= cmm_pkg::ADDR_VRAM_LO && a <= cmm_pkg::ADDR_VRAM_HI;
		high   = a >= cmm_pkg::ADDR_HRAM_LO && a <= cmm_pkg::ADDR_HRAM_HI;
		wr     = op == cmm_pkg::OP_WRITE;

		mem.flat_we      = (wr && !unused && !vram && !high) ||
		                   (op == cmm_pkg::OP_LOAD_RAM);
		mem.flat_addr    = (op == cmm_pkg::OP_LOAD_RAM) ? a : a2;
		mem.rom_we       = op == cmm_pkg::OP_LOAD_ROM;
		mem.rom_addr     = (op == cmm_pkg::OP_LOAD_ROM) ?
		                   {item.rom_bank, a[cmm_pkg::ROM_OFS_W-1:0]} :
		                   {a2[cmm_pkg::ROM_OFS_W] & ~single_bank,
		                    a2[cmm_pkg::ROM_OFS_W-1:0]};
		mem.vram_idx     = a[cmm_pkg::VRAM_IDX_W:1];
		mem.vram_even_we = wr && vram && !a[0];
		mem.vram_odd_we  = wr && vram && a[0];
		mem.high_we      = wr && high;
		mem.high_addr    = a[cmm_pkg::HRAM_ADDR_W-1:0];

		s1.fault    = 1'b0;
		s1.reg_byte = io_rd.data;
		if (op != cmm_pkg::OP_READ) begin
			s1.src = cmm_pkg::SRC_ZERO;
		end else if (io_rd.hit) begin
			s1.src = cmm_pkg::SRC_REG;
		end else if (unused) begin
			s1.src   = cmm_pkg::SRC_ZERO;
			s1.fault = 1'b1;
		end else if (vram) begin
			s1.src = cmm_pkg::SRC_VRAM;
		end else if (a2 < cmm_pkg::ADDR_BOOT_END && !boot_off) begin
			s1.src = cmm_pkg::SRC_FLAT;
		end else if (a2 < cmm_pkg::ADDR_ROM_END) begin
			s1.src = cmm_pkg::SRC_ROM;
		end else if (high) begin
			s1.src = cmm_pkg::SRC_HIGH;
		end else begin
			s1.src = cmm_pkg::SRC_FLAT;
		end

		s1.odd         = a[0];
		s1.data        = item.data;
		s1.tile_valid  = wr && vram && a <= cmm_pkg::ADDR_TILE_HI;
		s1.bg_touched  = wr && vram && a > cmm_pkg::ADDR_TILE_HI;
		s1.tile_number = a[12:4];
		s1.tile_row    = a[3:1];
	end

endmodule

[hdl/cmm_result.sv]
// Result formation: read data select and tile row pixel decode.
module cmm_result (
	input  cmm_pkg::cmm_s1_t  s1,
	input  logic [7:0]        flat_rd,
	input  logic [7:0]        rom_rd,
	input  logic [7:0]        vram_even_rd,
	input  logic [7:0]        vram_odd_rd,
	input  logic [7:0]        high_rd,
	output cmm_pkg::cmm_out_t res
);

	logic [7:0]  lo;
	logic [7:0]  hi;
	logic [15:0] px;

	always_comb begin
		lo = s1.odd ? vram_even_rd : s1.data;
		hi = s1.odd ? s1.data : vram_odd_rd;
		for (int x = 0; x < 8; x++) begin
			px[2*x]   = lo[7-x];
			px[2*x+1] = hi[7-x];
		end

		case (s1.src)
			cmm_pkg::SRC_REG:  res.read_data = s1.reg_byte;
			cmm_pkg::SRC_VRAM: res.read_data = s1.odd ? vram_odd_rd : vram_even_rd;
			cmm_pkg::SRC_ROM:  res.read_data = rom_rd;
			cmm_pkg::SRC_HIGH: res.read_data = high_rd;
			cmm_pkg::SRC_FLAT: res.read_data = flat_rd;
			default:           res.read_data = 8'd0;
		endcase

		res.access_fault       = s1.fault;
		res.tile_row_valid     = s1.tile_valid;
		res.tile_number        = s1.tile_valid ? s1.tile_number : 9'd0;
		res.tile_row_number    = s1.tile_valid ? s1.tile_row : 3'd0;
		res.tile_pixels        = s1.tile_valid ? px : 16'd0;
		res.background_touched = s1.bg_touched;
	end

endmodule

[verif/console_memory_map_with_tile_decode_tb.sv]
// Self-checking testbench for the console memory map: directed and random bus accesses.
`timescale 1ns / 1ps

module console_memory_map_with_tile_decode_tb;
	import cmm_pkg::*;

	localparam int ROUNDS       = 5;
	localparam int ROUND_ITEMS  = 370;
	localparam int LIMIT_CYCLES = 2000000;
	localparam int DRAIN_LIMIT  = 5000;
	localparam int SETTLE       = 4;

	typedef enum {FLOW, LIGHT, HEAVY, HOLD} stall_mode_t;

	class cmm_bus_model;
		bit [7:0] flat [FLAT_DEPTH];
		bit [7:0] rom [ROM_DEPTH];
		bit       rom_loaded [ROM_DEPTH];
		bit [7:0] vram [2 * VRAM_BANK_DEPTH];
		bit [7:0] hram [HRAM_DEPTH];
		bit       boot_off;
		bit [1:0] joy_col;
		bit [7:0] scy, scx, lcdc, tima, tma;
		bit [2:0] tac;
		bit       single_bank;
		cmm_out_t pending_rsp [$];
		int       mism;

		task report(string msg);
			if (mism < 40)
				$display("%0t %s", $time, msg);
			mism++;
		endtask

		function int rom_slot(logic [15:0] a);
			if (a >= ADDR_ROM_END || (a < ADDR_BOOT_END && !boot_off))
				return -1;
			if (a < ROM_BANK_BYTES)
				return int'(a);
			return (single_bank ? 0 : ROM_BANK_BYTES) + int'(a) - ROM_BANK_BYTES;
		endfunction

		function logic [15:0] row_pixels(logic [12:0] base);
			logic [7:0]  lo, hi;
			logic [15:0] px;
			lo = vram[base];
			hi = vram[base + 13'd1];
			for (int x = 0; x < 8; x++) begin
				px[2 * x]     = lo[7 - x];
				px[2 * x + 1] = hi[7 - x];
			end
			return px;
		endfunction

		function logic [7:0] fetch_byte(cmm_in_t it, output logic fault);
			logic [15:0] a;
			int          s;
			a = it.address;
			fault = 1'b0;
			if (a == ADDR_JOYP) begin
				if (joy_col == JOYP_COL_ONE)
					return it.keys_group_one;
				if (joy_col == JOYP_COL_TWO)
					return it.keys_group_two;
				return 8'h00;
			end
			if (a >= ADDR_UNUSED_LO && a <= ADDR_UNUSED_HI) begin
				fault = 1'b1;
				return 8'h00;
			end
			if (a >= ADDR_VRAM_LO && a <= ADDR_VRAM_HI)
				return vram[a[12:0]];
			case (a)
				ADDR_SCY:  return scy;
				ADDR_LCDC: return lcdc;
				ADDR_SCX:  return scx;
				ADDR_LY:   return it.current_scanline;
				ADDR_DIV:  return it.divider_value;
				ADDR_TIMA: return tima;
				ADDR_TMA:  return tma;
				ADDR_TAC:  return {5'b0, tac};
				default: ;
			endcase
			if (a >= ADDR_ECHO_LO && a < ADDR_ECHO_END)
				a = a - ECHO_OFFSET;
			s = rom_slot(a);
			if (s >= 0)
				return rom[s];
			if (a >= ADDR_HRAM_LO && a <= ADDR_HRAM_HI)
				return hram[a[6:0]];
			return flat[a];
		endfunction

		function void take_access(cmm_in_t it);
			cmm_out_t    r;
			logic [15:0] a;
			logic [12:0] base;
			logic        fault;
			r = '0;
			a = it.address;
			case (op_t'(it.op))
				OP_READ: begin
					r.read_data = fetch_byte(it, fault);
					r.access_fault = fault;
				end
				OP_WRITE: begin
					if (!(a >= ADDR_UNUSED_LO && a <= ADDR_UNUSED_HI)) begin
						if (a == ADDR_JOYP)
							joy_col = it.data[5:4];
						if (a == ADDR_BOOT_OFF)
							boot_off = 1'b1;
						case (a)
							ADDR_SCY:  scy = it.data;
							ADDR_LCDC: lcdc = it.data;
							ADDR_TIMA: tima = it.data;
							ADDR_TMA:  tma = it.data;
							ADDR_TAC:  tac = it.data[2:0];
							ADDR_SCX:  scx = it.data;
							default: ;
						endcase
						if (a >= ADDR_VRAM_LO && a <= ADDR_VRAM_HI) begin
							vram[a[12:0]] = it.data;
							if (a <= ADDR_TILE_HI) begin
								base = {a[12:1], 1'b0};
								r.tile_row_valid = 1'b1;
								r.tile_number = base[12:4];
								r.tile_row_number = base[3:1];
								r.tile_pixels = row_pixels(base);
							end else begin
								r.background_touched = 1'b1;
							end
						end else if (a >= ADDR_HRAM_LO && a <= ADDR_HRAM_HI) begin
							hram[a[6:0]] = it.data;
						end else begin
							if (a >= ADDR_ECHO_LO && a < ADDR_ECHO_END)
								a = a - ECHO_OFFSET;
							flat[a] = it.data;
						end
					end
				end
				OP_LOAD_ROM: begin
					rom[{it.rom_bank, a[13:0]}] = it.data;
					rom_loaded[{it.rom_bank, a[13:0]}] = 1'b1;
				end
				default: flat[a] = it.data;
			endcase
			pending_rsp.push_back(r);
		endfunction

		task cmp(string field, logic [15:0] got, logic [15:0] want);
			if (got !== want)
				report($sformatf("%s: got %0h want %0h", field, got, want));
		endtask

		task match_rsp(cmm_out_t got);
			cmm_out_t want;
			if (pending_rsp.size() == 0) begin
				report("result item with none expected");
				return;
			end
			want = pending_rsp.pop_front();
			cmp("read_data", got.read_data, want.read_data);
			cmp("access_fault", got.access_fault, want.access_fault);
			cmp("tile_row_valid", got.tile_row_valid, want.tile_row_valid);
			cmp("tile_number", got.tile_number, want.tile_number);
			cmp("tile_row_number", got.tile_row_number, want.tile_row_number);
			cmp("tile_pixels", got.tile_pixels, want.tile_pixels);
			cmp("background_touched", got.background_touched, want.background_touched);
		endtask
	endclass

	logic     clk;
	logic     arst_n;
	logic     req_valid;
	logic     req_stall;
	cmm_in_t  req;
	logic     rsp_valid;
	logic     rsp_stall;
	cmm_out_t rsp;
	logic     cfg_valid;
	logic     cfg_ready;
	logic     cfg_data;

	cmm_bus_model sb = new;
	int           round;
	bit           pair_pending;
	cmm_in_t      pair_item;

	console_memory_map_with_tile_decode u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin : watchdog
		#(LIMIT_CYCLES * 20);
		$display("console_memory_map_with_tile_decode_tb: done, errors");
		$finish;
	end

	function automatic cmm_in_t mk(op_t op, logic [15:0] a, logic [7:0] d, logic bank);
		cmm_in_t it;
		it.op = op;
		it.address = a;
		it.data = d;
		it.rom_bank = bank;
		it.keys_group_one = 8'($urandom);
		it.keys_group_two = 8'($urandom);
		it.current_scanline = 8'($urandom);
		it.divider_value = 8'($urandom);
		return it;
	endfunction

	function automatic logic [15:0] near(int lo, int hi);
		case ($urandom_range(0, 3))
			0, 1: return 16'(lo + int'($urandom_range(0, 15)));
			2: return 16'(hi - int'($urandom_range(0, 15)));
			default: return 16'(lo + int'($urandom_range(0, hi - lo)));
		endcase
	endfunction

	function automatic op_t rw_op();
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: return OP_READ;
			9: return OP_LOAD_RAM;
			default: return OP_WRITE;
		endcase
	endfunction

	function automatic cmm_in_t next_access();
		cmm_in_t it;
		int      pick;
		int      slot;
		if (pair_pending) begin
			pair_pending = 1'b0;
			return pair_item;
		end
		it = mk(rw_op(), 16'($urandom), 8'($urandom), 1'($urandom));
		pick = $urandom_range(0, 99);
		if (pick < 12) begin
			it.op = OP_LOAD_ROM;
			it.address = {2'($urandom), 14'(near(0, 16'h3FFF))};
		end else if (pick < 26) begin
			it.op = OP_READ;
			it.address = {1'b0, 1'($urandom), 14'(near(0, 16'h3FFF))};
		end else if (pick < 38) begin
			it.op = OP_WRITE;
			it.address = near(ADDR_VRAM_LO, ADDR_TILE_HI) & 16'hFFFE;
			if ($urandom_range(0, 4) != 0) begin
				pair_item = it;
				pair_item.address[0] = 1'b1;
				pair_item.data = 8'($urandom);
				pair_pending = 1'b1;
			end else begin
				it.address[0] = 1'($urandom);
			end
		end else if (pick < 43) begin
			it.address = near(16'h9800, ADDR_VRAM_HI);
		end else if (pick < 51) begin
			it.op = OP_READ;
			it.address = near(ADDR_VRAM_LO, ADDR_VRAM_HI);
		end else if (pick < 61) begin
			it.address = near(16'hA000, 16'hDFFF);
		end else if (pick < 67) begin
			it.address = near(ADDR_ECHO_LO, 16'hFDFF);
		end else if (pick < 71) begin
			it.address = near(16'hFE00, ADDR_UNUSED_HI);
		end else if (pick < 83) begin
			case ($urandom_range(0, 11))
				0: it.address = ADDR_JOYP;
				1: it.address = ADDR_DIV;
				2: it.address = ADDR_TIMA;
				3: it.address = ADDR_TMA;
				4: it.address = ADDR_TAC;
				5: it.address = ADDR_LCDC;
				6: it.address = ADDR_SCY;
				7: it.address = ADDR_SCX;
				8: it.address = ADDR_LY;
				9: it.address = ADDR_BOOT_OFF;
				10: it.address = 16'hFF41;
				default: it.address = 16'(ADDR_JOYP + $urandom_range(1, 16'h7F));
			endcase
		end else if (pick < 89) begin
			it.address = near(ADDR_HRAM_LO, 16'hFFFF);
		end else if (pick < 93) begin
			it.address = near(0, 16'h00FF);
		end else begin
			it.op = 2'($urandom);
		end
		if (round == 0 && it.op == OP_WRITE && it.address == ADDR_BOOT_OFF)
			it.op = OP_READ;
		if (it.op == OP_READ) begin
			slot = sb.rom_slot(it.address);
			if (slot >= 0 && !sb.rom_loaded[slot]) begin
				it.op = OP_LOAD_ROM;
				it.rom_bank = slot[14];
			end
		end
		return it;
	endfunction

	task automatic send_item(cmm_in_t it);
		req <= it;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		sb.take_access(it);
	endtask

	task automatic idle(int n);
		req_valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic write_cfg(logic v);
		cfg_data <= v;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		sb.single_bank = v;
	endtask

	task automatic drain();
		int guard;
		req_valid <= 1'b0;
		guard = 0;
		while (sb.pending_rsp.size() != 0 && guard < DRAIN_LIMIT) begin
			@(posedge clk);
			guard++;
		end
		if (sb.pending_rsp.size() != 0) begin
			sb.report($sformatf("%0d result items never arrived", sb.pending_rsp.size()));
			sb.pending_rsp.delete();
		end
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic run_random(int count);
		int      done;
		int      burst;
		int      gap;
		cmm_in_t it;
		done = 0;
		while (done < count) begin
			burst = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 150) : $urandom_range(1, 24);
			repeat (burst) begin
				it = next_access();
				send_item(it);
				if (!(it.op == OP_WRITE && it.address >= ADDR_UNUSED_LO &&
						it.address <= ADDR_UNUSED_HI))
					done++;
			end
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap != 0)
				idle(gap);
		end
	endtask

	initial begin : receiver
		int          left;
		stall_mode_t mode;
		bit          held;
		rsp_stall <= 1'b0;
		left = 0;
		mode = FLOW;
		held = 1'b0;
		forever begin
			@(posedge clk);
			if (rsp_valid && !rsp_stall)
				sb.match_rsp(rsp);
			if (left == 0) begin
				mode = stall_mode_t'($urandom_range(0, 2));
				left = $urandom_range(4, 60);
				if (!held && rsp_valid) begin
					mode = HOLD;
					left = 400;
					held = 1'b1;
				end else if ($urandom_range(0, 15) == 0) begin
					mode = HOLD;
					left = $urandom_range(40, 200);
				end
			end
			left--;
			case (mode)
				FLOW:  rsp_stall <= 1'b0;
				LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
				HEAVY: rsp_stall <= ($urandom_range(0, 9) < 6);
				default: rsp_stall <= 1'b1;
			endcase
		end
	end

	initial begin : stimulus
		int r;
		arst_n <= 1'b0;
		req_valid <= 1'b0;
		req <= '0;
		cfg_valid <= 1'b0;
		cfg_data <= 1'b0;
		pair_pending = 1'b0;
		round = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		for (r = 0; r < ROUNDS; r++) begin
			round = r;
			if (r != 0)
				drain();
			write_cfg(r[0]);
			if (r == 0) begin
				send_item(mk(OP_LOAD_RAM, 16'h0000, 8'hA5, 1'b0));
				send_item(mk(OP_READ, 16'h0000, 8'h00, 1'b0));
				send_item(mk(OP_LOAD_ROM, 16'hC000, 8'h3C, 1'b0));
				send_item(mk(OP_LOAD_ROM, 16'hFFFF, 8'hFF, 1'b1));
				send_item(mk(OP_WRITE, 16'h7FFF, 8'h00, 1'b0));
				send_item(mk(OP_READ, 16'h7FFF, 8'h00, 1'b0));
				send_item(mk(OP_WRITE, ADDR_VRAM_LO, 8'hF0, 1'b0));
				send_item(mk(OP_WRITE, 16'h8001, 8'h0F, 1'b0));
				send_item(mk(OP_WRITE, ADDR_TILE_HI, 8'hFF, 1'b0));
				send_item(mk(OP_WRITE, ADDR_VRAM_HI, 8'h12, 1'b0));
				send_item(mk(OP_READ, ADDR_UNUSED_LO, 8'h00, 1'b0));
				send_item(mk(OP_WRITE, ADDR_UNUSED_HI, 8'h77, 1'b0));
				send_item(mk(OP_WRITE, ADDR_JOYP, 8'h10, 1'b0));
				send_item(mk(OP_READ, ADDR_JOYP, 8'h00, 1'b0));
				send_item(mk(OP_WRITE, ADDR_JOYP, 8'h30, 1'b0));
				send_item(mk(OP_READ, ADDR_JOYP, 8'h00, 1'b0));
				send_item(mk(OP_READ, ADDR_LY, 8'h00, 1'b0));
				send_item(mk(OP_WRITE, ADDR_DIV, 8'h99, 1'b0));
				send_item(mk(OP_READ, ADDR_DIV, 8'h00, 1'b0));
				send_item(mk(OP_WRITE, 16'hFDFF, 8'h44, 1'b0));
				send_item(mk(OP_READ, 16'hDDFF, 8'h00, 1'b0));
				send_item(mk(OP_WRITE, ADDR_HRAM_HI, 8'h55, 1'b0));
				send_item(mk(OP_READ, 16'hFFFF, 8'h00, 1'b0));
			end
			if (r == 1) begin
				send_item(mk(OP_WRITE, ADDR_BOOT_OFF, 8'h01, 1'b0));
				send_item(mk(OP_READ, 16'h0000, 8'h00, 1'b0));
			end
			run_random(ROUND_ITEMS);
		end
		drain();
		if (sb.mism == 0)
			$display("console_memory_map_with_tile_decode_tb: done, clean");
		else
			$display("console_memory_map_with_tile_decode_tb: done, errors");
		$finish;
	end

endmodule
